@@ rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Field widths, operation and clamp codes, and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Fixed field widths
  localparam int IDX_W  = 6;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 7;

  // Breakpoint count after reset, before saturation to the table depth
  localparam int POINTS_RESET = 64;

  // Input item operations
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Result clamp kinds
  localparam logic [KIND_W-1:0] KIND_INSIDE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BELOW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABOVE  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;      // capture query abscissa, clear scan flags
    logic load;       // write one breakpoint
    logic scan_rd;    // read abscissa at scan address
    logic y_first;    // read first ordinate, latch segment decision
    logic y_second;   // capture first ordinate, read the next one
    logic y_cap1;     // capture second ordinate, form differences
    logic mul;        // form product
    logic div_load;   // load divider from product
    logic div_step;   // one restoring division step
    logic out_load;   // load result register
  } pli_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic interp;     // query falls strictly inside a segment
  } pli_sts_t;

endpackage

@@ rtl/pli_in_if.sv @@
// ----------------------------------------------------------------------------
// pli_in_if: input item channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
interface pli_in_if import pli_pkg::*; #(
  parameter int VALUE_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [IDX_W-1:0]              entry_index;
  logic signed [VALUE_WIDTH-1:0] entry_x;
  logic signed [VALUE_WIDTH-1:0] entry_y;
  logic signed [VALUE_WIDTH-1:0] query_x;

  modport source (output valid, output opcode, output entry_index, output entry_x,
                  output entry_y, output query_x, input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_x,
                  input entry_y, input query_x, output ready);
endinterface

@@ rtl/pli_out_if.sv @@
// ----------------------------------------------------------------------------
// pli_out_if: result item channel
// Valid/ready channel carrying one interpolated result.
// ----------------------------------------------------------------------------
interface pli_out_if import pli_pkg::*; #(
  parameter int VALUE_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_y;
  logic [IDX_W-1:0]              segment_index;
  logic [KIND_W-1:0]             clamp_kind;

  modport source (output valid, output result_y, output segment_index,
                  output clamp_kind, input ready);
  modport sink   (input valid, input result_y, input segment_index,
                  input clamp_kind, output ready);
endinterface

@@ rtl/pli_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pli_cfg_if: configuration write channel
// Valid/ready channel carrying the breakpoint count register.
// ----------------------------------------------------------------------------
interface pli_cfg_if import pli_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] points_in_use;

  modport source (output valid, output points_in_use, input ready);
  modport sink   (input valid, input points_in_use, output ready);
endinterface

@@ rtl/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with linear interpolation
// Load items write one breakpoint (x, y); query items return the ordinate
// interpolated at an abscissa, with the segment used and a clamp kind.
// ----------------------------------------------------------------------------
// A load item is written as soon as it is accepted. A query scans the abscissa
// memory once, one entry per cycle, then reads one or two ordinates; a query
// that falls inside a segment also runs a multiply and a restoring divider of
// VALUE_WIDTH+1 steps. The table scan on the single read port of the abscissa
// memory and the divider set how long a query runs. The result sits in an
// output register, so the next item is taken while an earlier result waits.
// Breakpoint memories are not cleared at reset; every entry taking part in a
// query must be loaded first.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  pli_in_if.sink      in_ch,
  pli_out_if.source   out_ch,
  pli_cfg_if.sink     cfg_ch
);

  localparam int AW = $clog2(MAX_POINTS);

  pli_cmd_t      cmd;
  pli_sts_t      sts;
  logic [AW-1:0] scan_addr;

  // Controller
  pli_ctrl #(.MAX_POINTS(MAX_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_opcode  (in_ch.opcode),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cfg_valid  (cfg_ch.valid),
    .cfg_points (cfg_ch.points_in_use),
    .cfg_ready  (cfg_ch.ready),
    .cmd        (cmd),
    .sts        (sts),
    .scan_addr  (scan_addr)
  );

  // Datapath
  pli_dp #(.MAX_POINTS(MAX_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .scan_addr     (scan_addr),
    .entry_index   (in_ch.entry_index),
    .entry_x       (in_ch.entry_x),
    .entry_y       (in_ch.entry_y),
    .query_x       (in_ch.query_x),
    .sts           (sts),
    .result_y      (out_ch.result_y),
    .segment_index (out_ch.segment_index),
    .clamp_kind    (out_ch.clamp_kind)
  );

endmodule

@@ rtl/pli_ram.sv @@
// ----------------------------------------------------------------------------
// pli_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

@@ rtl/pli_dp.sv @@
// ----------------------------------------------------------------------------
// pli_dp: interpolator datapath
// Breakpoint memories, scan flags, segment decision, multiplier, restoring
// divider and result register.
// ----------------------------------------------------------------------------
module pli_dp import pli_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_cmd_t                      cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] scan_addr,
  input  logic [IDX_W-1:0]              entry_index,
  input  logic signed [VALUE_WIDTH-1:0] entry_x,
  input  logic signed [VALUE_WIDTH-1:0] entry_y,
  input  logic signed [VALUE_WIDTH-1:0] query_x,
  output pli_sts_t                      sts,
  output logic signed [VALUE_WIDTH-1:0] result_y,
  output logic [IDX_W-1:0]              segment_index,
  output logic [KIND_W-1:0]             clamp_kind
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int PW = 2 * W + 1;

  // Memories
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        y_addr;
  logic [W-1:0]         x_rdata;
  logic [W-1:0]         y_rdata;

  // Scan state
  logic                 scan_vld_r;
  logic [AW-1:0]        scan_idx_r;
  logic signed [W-1:0]  q_r;
  logic                 hit_r;
  logic [AW-1:0]        hit_idx_r;
  logic                 seg_r;
  logic [AW-1:0]        seg_idx_r;
  logic signed [W-1:0]  xa_r;
  logic signed [W-1:0]  xb_r;
  logic signed [W-1:0]  xfirst_r;
  logic signed [W-1:0]  xlast_r;
  logic [AW-1:0]        last_idx_r;
  logic signed [W-1:0]  xprev_r;
  logic signed [W-1:0]  x_cur;

  // Decision
  logic [AW-1:0]        ya;
  logic [KIND_W-1:0]    kind;
  logic [AW-1:0]        ya_r;
  logic [KIND_W-1:0]    kind_r;

  // Arithmetic
  logic signed [W-1:0]  y0_r;
  logic signed [W:0]    dq_full;
  logic signed [W:0]    dx_full;
  logic signed [W:0]    dy_full;
  logic [W:0]           mag;
  logic [W-1:0]         dq_r;
  logic [W-1:0]         dx_r;
  logic [W:0]           mag_r;
  logic                 neg_r;
  logic [PW-1:0]        prod_full;
  logic [PW-1:0]        prod_r;
  logic [W-1:0]         rem_r;
  logic [W:0]           sh_r;
  logic [W:0]           trial;
  logic [W:0]           trial_diff;
  logic                 ge;
  logic signed [W+1:0]  y0_ext;
  logic signed [W+1:0]  quo_ext;
  logic signed [W+1:0]  res_full;
  logic signed [W-1:0]  res_y;

  // Write a breakpoint only inside the table
  assign wr_en   = cmd.load && (32'(entry_index) < 32'(MAX_POINTS));
  assign wr_addr = AW'(entry_index);

  pli_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_x),
    .rd_addr (scan_addr),
    .rd_data (x_rdata)
  );

  pli_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_y),
    .rd_addr (y_addr),
    .rd_data (y_rdata)
  );

  assign x_cur = signed'(x_rdata);

  // Segment decision: exact hit, then segment, then clamps
  always_comb begin
    ya   = '0;
    kind = KIND_INSIDE;
    if (hit_r) begin
      ya = hit_idx_r;
    end else if (seg_r) begin
      ya = seg_idx_r;
    end else if (q_r < xfirst_r) begin
      kind = KIND_BELOW;
    end else if (q_r > xlast_r) begin
      ya   = last_idx_r;
      kind = KIND_ABOVE;
    end
  end

  assign sts.interp = !hit_r && seg_r;
  assign y_addr     = cmd.y_first ? ya : ya_r + AW'(1);

  // Scan control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      seg_r      <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
      if (cmd.start) begin
        hit_r <= 1'b0;
        seg_r <= 1'b0;
      end else if (scan_vld_r) begin
        if (!hit_r && x_cur == q_r) begin
          hit_r <= 1'b1;
        end
        if (scan_idx_r != '0 && !seg_r && q_r > xprev_r && q_r <= x_cur) begin
          seg_r <= 1'b1;
        end
      end
    end
  end

  // Scan payload: first and last abscissa, hit and segment positions
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_addr;
    if (cmd.start) begin
      q_r <= query_x;
    end
    if (scan_vld_r) begin
      if (scan_idx_r == '0) begin
        xfirst_r <= x_cur;
      end
      if (!hit_r && x_cur == q_r) begin
        hit_idx_r <= scan_idx_r;
      end
      if (scan_idx_r != '0 && !seg_r && q_r > xprev_r && q_r <= x_cur) begin
        seg_idx_r <= scan_idx_r - AW'(1);
        xa_r      <= xprev_r;
        xb_r      <= x_cur;
      end
      xprev_r    <= x_cur;
      xlast_r    <= x_cur;
      last_idx_r <= scan_idx_r;
    end
  end

  // Differences of the segment
  assign dq_full = {q_r[W-1], q_r} - {xa_r[W-1], xa_r};
  assign dx_full = {xb_r[W-1], xb_r} - {xa_r[W-1], xa_r};
  assign dy_full = signed'({y_rdata[W-1], y_rdata}) - {y0_r[W-1], y0_r};
  assign mag     = dy_full[W] ? unsigned'(-dy_full) : unsigned'(dy_full);

  assign prod_full = dq_r * mag_r;

  // One restoring step: the remainder always stays below the divisor
  assign trial      = {rem_r, sh_r[W]};
  assign trial_diff = trial - {1'b0, dx_r};
  assign ge         = trial >= {1'b0, dx_r};

  // Final add of the scaled difference
  assign y0_ext   = {{2{y0_r[W-1]}}, y0_r};
  assign quo_ext  = signed'({1'b0, sh_r});
  assign res_full = neg_r ? y0_ext - quo_ext : y0_ext + quo_ext;
  assign res_y    = sts.interp ? res_full[W-1:0] : y0_r;

  // Arithmetic pipeline and result register
  always_ff @(posedge clk) begin
    if (cmd.y_first) begin
      ya_r   <= ya;
      kind_r <= kind;
    end
    if (cmd.y_second) begin
      y0_r <= signed'(y_rdata);
    end
    if (cmd.y_cap1) begin
      dq_r  <= dq_full[W-1:0];
      dx_r  <= dx_full[W-1:0];
      mag_r <= mag;
      neg_r <= dy_full[W];
    end
    if (cmd.mul) begin
      prod_r <= prod_full;
    end
    if (cmd.div_load) begin
      rem_r <= prod_r[PW-1:W+1];
      sh_r  <= prod_r[W:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_diff[W-1:0] : trial[W-1:0];
      sh_r  <= {sh_r[W-1:0], ge};
    end
    if (cmd.out_load) begin
      result_y      <= res_y;
      segment_index <= IDX_W'(ya_r);
      clamp_kind    <= kind_r;
    end
  end

endmodule

@@ rtl/pli_ctrl.sv @@
// ----------------------------------------------------------------------------
// pli_ctrl: interpolator controller
// Sequences table scan, ordinate reads, multiply and divide steps, holds the
// breakpoint count register and the result valid flag.
// ----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_opcode,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_valid,
  input  logic [CFG_W-1:0]              cfg_points,
  output logic                          cfg_ready,
  output pli_cmd_t                      cmd,
  input  pli_sts_t                      sts,
  output logic [$clog2(MAX_POINTS)-1:0] scan_addr
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = $clog2(VALUE_WIDTH + 1);
  localparam int NRST = (POINTS_RESET > MAX_POINTS) ? MAX_POINTS : POINTS_RESET;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_Y0, S_Y1, S_Y2, S_MUL, S_LOAD, S_DIV, S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign scan_addr = cnt_r[AW-1:0];

  // Saturate the breakpoint count on write
  always_comb begin
    n_nxt = n_r;
    if (cfg_valid) begin
      if (cfg_points < CFG_W'(2)) begin
        n_nxt = CW'(2);
      end else if (32'(cfg_points) > 32'(MAX_POINTS)) begin
        n_nxt = CW'(MAX_POINTS);
      end else begin
        n_nxt = CW'(cfg_points);
      end
    end
  end

  // Sequence one item
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_QUERY) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (cnt_r == n_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_Y0;
      end
      S_Y0: begin
        cmd.y_first = 1'b1;
        state_nxt   = S_Y1;
      end
      S_Y1: begin
        cmd.y_second = 1'b1;
        state_nxt    = sts.interp ? S_Y2 : S_FIN;
      end
      S_Y2: begin
        cmd.y_cap1 = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == SW'(VALUE_WIDTH)) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_FIN: begin
        // Hand over once the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      n_r         <= CW'(NRST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan address stays inside the active table
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r < n_r)
    else $error("scan address beyond breakpoint count");

  // Breakpoint count stays saturated
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    n_r >= CW'(2) && n_r <= CW'(MAX_POINTS))
    else $error("breakpoint count out of range");

  // Division never runs past its last step
  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r <= SW'(VALUE_WIDTH))
    else $error("divider step count overrun");

  // A result only appears from the final state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result valid raised outside final state");

  // A query leaves the idle state at once
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_opcode == OP_QUERY) |=> !in_ready)
    else $error("query accepted but block still idle");

endmodule

@@ tb/piecewise_linear_interpolator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_test: self-checking bench of the interpolator
// Fills the breakpoint table, walks a short table of directed loads, queries
// and count changes, then runs random phases: each phase sets the breakpoint
// count, loads an ascending table of random shape or writes random entries,
// and fires queries at hits, segment interiors, both clamps and random
// abscissae. Every query result is checked against a local model of the
// lookup or a typed-in value, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_test;
  import pli_pkg::*;

  localparam int VW           = 24;
  localparam int NPTS         = 64;
  localparam int TAIL_CYCLES  = 120;
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 1550;
  localparam int REPORT_LIMIT = 10;
  localparam int DIR_ROWS     = 25;

  localparam logic signed [VW-1:0] VAL_MIN = 24'sh800000;
  localparam logic signed [VW-1:0] VAL_MAX = 24'sh7FFFFF;

  // One lookup result as it leaves the block
  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [IDX_W-1:0]     segment;
    logic [KIND_W-1:0]    clamp;
  } lookup_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_POINTS
  } row_kind_t;

  // Directed step: xv is the load abscissa or the query abscissa
  typedef struct packed {
    row_kind_t            kind;
    logic [IDX_W-1:0]     idx;
    logic signed [VW-1:0] xv;
    logic signed [VW-1:0] yv;
    logic [CFG_W-1:0]     pts;
    logic                 given;
    lookup_t              res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pli_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  pli_out_if #(.VALUE_WIDTH(VW)) out_ch ();
  pli_cfg_if                     cfg_ch ();

  piecewise_linear_interpolator #(
    .MAX_POINTS  (NPTS),
    .VALUE_WIDTH (VW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the breakpoint table and the count register
  logic signed [VW-1:0] table_x [NPTS];
  logic signed [VW-1:0] table_y [NPTS];
  logic [CFG_W-1:0]     point_count;

  lookup_t queued_lookups [$];
  lookup_t lookup_head;
  int      mismatch_count = 0;
  int      items_accepted = 0;
  int      idle_cycles    = 0;
  int      burst_left     = 0;

  // Expected values are typed in only where they read straight off the table
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_QUERY,  0, VAL_MIN,  0, 0, 1'b1, '{0,        0,  KIND_BELOW}},
    '{ROW_QUERY,  0, VAL_MAX,  0, 0, 1'b1, '{16128,    63, KIND_ABOVE}},
    '{ROW_QUERY,  0, -110592,  0, 0, 1'b1, '{1280,     5,  KIND_INSIDE}},
    '{ROW_QUERY,  0, -110591,  0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, -106497,  0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_LOAD,   0, VAL_MIN,  VAL_MAX, 0, 1'b0, '{0,  0,  KIND_INSIDE}},
    '{ROW_LOAD,  63, VAL_MAX,  VAL_MIN, 0, 1'b0, '{0,  0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, VAL_MIN,  0, 0, 1'b1, '{VAL_MAX,  0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, VAL_MAX,  0, 0, 1'b1, '{VAL_MIN,  63, KIND_INSIDE}},
    '{ROW_QUERY,  0, -8388607, 0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, 8388606,  0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_LOAD,  10, -94208,   -5, 0, 1'b0, '{0,       0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, -94208,   0, 0, 1'b1, '{2304,     9,  KIND_INSIDE}},
    '{ROW_QUERY,  0, -94207,   0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_POINTS, 0, 0,        0, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, 0,        0, 0, 1'b1, '{256,      1,  KIND_ABOVE}},
    '{ROW_POINTS, 0, 0,        0, 127, 1'b0, '{0,      0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, 0,        0, 0, 1'b1, '{8192,     32, KIND_INSIDE}},
    '{ROW_POINTS, 0, 0,        0, 2, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_LOAD,   0, 1000,     -7, 0, 1'b0, '{0,       0,  KIND_INSIDE}},
    '{ROW_LOAD,   1, -1000,    9, 0, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, 0,        0, 0, 1'b1, '{-7,       0,  KIND_BELOW}},
    '{ROW_QUERY,  0, 5000,     0, 0, 1'b1, '{9,        1,  KIND_ABOVE}},
    '{ROW_POINTS, 0, 0,        0, 1, 1'b0, '{0,        0,  KIND_INSIDE}},
    '{ROW_QUERY,  0, -1000,    0, 0, 1'b1, '{9,        1,  KIND_INSIDE}}
  };

  // Saturate the count register to the range from 2 to the table depth
  function automatic int points_used();
    int n;
    n = point_count;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    return n;
  endfunction

  // Lookup of one abscissa against the shadow table
  function automatic lookup_t interpolate_at(input logic signed [VW-1:0] q);
    lookup_t r;
    int      n;
    int      i;
    bit      found;
    longint  qv, xa, xb, ya, yb, dy, mag, quo, res;
    n         = points_used();
    qv        = q;
    r.value   = table_y[0];
    r.segment = '0;
    r.clamp   = KIND_INSIDE;
    found     = 1'b0;
    // exact hit: lowest index wins
    for (i = 0; i < n && !found; i++) begin
      if (table_x[i] == q) begin
        r.value   = table_y[i];
        r.segment = IDX_W'(i);
        found     = 1'b1;
      end
    end
    // first segment with x[i] < q <= x[i+1]; equal neighbours never match
    for (i = 0; i + 1 < n && !found; i++) begin
      xa = table_x[i];
      xb = table_x[i + 1];
      if (qv > xa && qv <= xb) begin
        ya        = table_y[i];
        yb        = table_y[i + 1];
        dy        = yb - ya;
        mag       = (dy < 0) ? -dy : dy;
        quo       = ((qv - xa) * mag) / (xb - xa);
        res       = (dy < 0) ? ya - quo : ya + quo;
        r.value   = VW'(res);
        r.segment = IDX_W'(i);
        found     = 1'b1;
      end
    end
    if (!found) begin
      if (q < table_x[0]) begin
        r.value   = table_y[0];
        r.segment = '0;
        r.clamp   = KIND_BELOW;
      end else if (q > table_x[n - 1]) begin
        r.value   = table_y[n - 1];
        r.segment = IDX_W'(n - 1);
        r.clamp   = KIND_ABOVE;
      end
    end
    return r;
  endfunction

  // Field value biased towards the extremes and small magnitudes
  function automatic logic signed [VW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return VW'(int'($urandom_range(0, 2000)) - 1000);
      default: return VW'($urandom());
    endcase
  endfunction

  // Abscissa aimed at a hit, a segment interior, a clamp or anywhere
  function automatic logic signed [VW-1:0] random_abscissa(input int n);
    int     sel;
    int     i;
    longint lo_x, hi_x, first_x, last_x;
    sel     = $urandom_range(0, 9);
    i       = $urandom_range(0, n - 2);
    lo_x    = table_x[i];
    hi_x    = table_x[i + 1];
    first_x = table_x[0];
    last_x  = table_x[n - 1];
    if (sel <= 2)
      return table_x[$urandom_range(0, n - 1)];
    if (sel <= 5 && hi_x > lo_x)
      return VW'(lo_x + 1 + longint'($urandom_range(0, hi_x - lo_x - 1)));
    if (sel == 6 && first_x > -8388608)
      return VW'(-8388608 + longint'($urandom_range(0, first_x + 8388608 - 1)));
    if (sel == 7 && last_x < 8388607)
      return VW'(last_x + 1 + longint'($urandom_range(0, 8388607 - last_x - 1)));
    if (sel == 8) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return VW'($urandom());
  endfunction

  // Offer one item in bursts; on transfer update the table or queue a lookup
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic signed [VW-1:0] ex, input logic signed [VW-1:0] ey,
                           input logic signed [VW-1:0] qx, input bit use_given = 1'b0,
                           input lookup_t given = '0);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.entry_index <= idx;
    in_ch.entry_x     <= ex;
    in_ch.entry_y     <= ey;
    in_ch.query_x     <= qx;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD) begin
      table_x[idx] = ex;
      table_y[idx] = ey;
    end else begin
      queued_lookups.push_back(use_given ? given : interpolate_at(qx));
    end
    items_accepted++;
  endtask

  // Hold the input until every queued lookup has come back
  task automatic wait_for_lookups();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (queued_lookups.size() != 0);
  endtask

  // Write the count register once the block has gone idle
  task automatic set_point_count(input logic [CFG_W-1:0] pts);
    wait_for_lookups();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.points_in_use <= pts;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    point_count = pts;
  endtask

  // Load entries 0..n-1 with an ascending abscissa set of random spread
  task automatic load_breakpoints(input int n);
    longint xs [$];
    longint lo, width;
    int     shape;
    int     i;
    shape = $urandom_range(0, 3);
    if (shape == 1)
      width = $urandom_range(n, 4 * n);
    else if (shape == 2)
      width = $urandom_range(4 * n, 65535);
    else
      width = 16777215;
    lo = -8388608 + longint'($urandom_range(0, 16777215 - width));
    for (i = 0; i < n; i++)
      xs.push_back(lo + longint'($urandom_range(0, width)));
    xs.sort();
    if (shape == 3) begin
      xs[0]     = VAL_MIN;
      xs[n - 1] = VAL_MAX;
    end
    for (i = 0; i < n; i++)
      send_item(OP_LOAD, IDX_W'(i), VW'(xs[i]), random_value(), random_value());
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stretches of fixed ready odds, from never stalling to mostly stalled
  initial begin : result_stall
    int ready_pct;
    out_ch.ready <= 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 50;
        2:       ready_pct = 12;
        default: ready_pct = 75;
      endcase
      repeat ($urandom_range(10, 150)) begin
        @(posedge clk);
        out_ch.ready <= (int'($urandom_range(0, 99)) < ready_pct);
      end
    end
  end

  // Check each result transfer against the oldest queued lookup
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (queued_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: value %0d segment %0d clamp %0d",
                   out_ch.result_y, out_ch.segment_index, out_ch.clamp_kind);
      end else begin
        lookup_head = queued_lookups.pop_front();
        if (out_ch.result_y !== lookup_head.value ||
            out_ch.segment_index !== lookup_head.segment ||
            out_ch.clamp_kind !== lookup_head.clamp) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("lookup mismatch: expected value %0d segment %0d clamp %0d, got %0d %0d %0d",
                     lookup_head.value, lookup_head.segment, lookup_head.clamp,
                     out_ch.result_y, out_ch.segment_index, out_ch.clamp_kind);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** piecewise_linear_interpolator: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    dir_row_t         row;
    logic [CFG_W-1:0] pts;
    int               r;
    int               n;
    int               pick;
    point_count = CFG_W'(POINTS_RESET);
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_LOAD;
    in_ch.entry_index    <= '0;
    in_ch.entry_x        <= '0;
    in_ch.entry_y        <= '0;
    in_ch.query_x        <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.points_in_use <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole table so that no query reads an unwritten entry
    for (r = 0; r < NPTS; r++)
      send_item(OP_LOAD, IDX_W'(r), VW'((r - 32) * 4096), VW'(r * 256), random_value());

    // directed steps
    for (r = 0; r < DIR_ROWS; r++) begin
      row = directed_rows[r];
      case (row.kind)
        ROW_LOAD:   send_item(OP_LOAD, row.idx, row.xv, row.yv, random_value());
        ROW_QUERY:  send_item(OP_QUERY, IDX_W'($urandom()), random_value(), random_value(),
                              row.xv, row.given, row.res);
        default:    set_point_count(row.pts);
      endcase
    end

    // random phases: set a count, reload the table, then query it
    while (items_accepted < ITEM_TARGET) begin
      pick = $urandom_range(0, 15);
      if (pick == 0)      pts = 7'd64;
      else if (pick == 1) pts = 7'd127;
      else if (pick == 2) pts = 7'd0;
      else if (pick == 3) pts = 7'd1;
      else if (pick == 4) pts = CFG_W'($urandom());
      else                pts = CFG_W'($urandom_range(2, 8));
      set_point_count(pts);
      n = points_used();
      if ($urandom_range(0, 4) != 0)
        load_breakpoints(n);
      else
        repeat ($urandom_range(1, 6))
          send_item(OP_LOAD, IDX_W'($urandom()), random_value(), random_value(),
                    random_value());
      repeat ($urandom_range(4, 24)) begin
        if ($urandom_range(0, 15) == 0)
          send_item(OP_LOAD, IDX_W'($urandom()), random_value(), random_value(),
                    random_value());
        else
          send_item(OP_QUERY, IDX_W'($urandom()), random_value(), random_value(),
                    random_abscissa(n));
      end
      if ($urandom_range(0, 5) == 0)
        wait_for_lookups();
    end

    // drain and let the block settle
    wait_for_lookups();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && queued_lookups.size() == 0) begin
      $display("** piecewise_linear_interpolator: PASSED **");
    end else begin
      $display("** piecewise_linear_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

@@ piecewise_linear_interpolator.f @@
rtl/pli_pkg.sv
rtl/pli_in_if.sv
rtl/pli_out_if.sv
rtl/pli_cfg_if.sv
rtl/pli_ram.sv
rtl/pli_dp.sv
rtl/pli_ctrl.sv
rtl/piecewise_linear_interpolator.sv
tb/piecewise_linear_interpolator_test.sv
